>>> src/bphc_pkg.sv
// Package for the button press/hold classifier: field widths, codes,
// register reset values and the press state type. No dependencies.
package bphc_pkg;

   // Fixed field widths of the request, response and register port
   localparam int LEVEL_BITS     = 12;
   localparam int INDEX_BITS     = 4;
   localparam int HOLD_BITS      = 16;
   localparam int STEP_BITS      = 8;
   localparam int STATE_BITS     = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   // Request modes
   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_READ = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TICK_STEP  = 2'd1;

   // Register reset values
   localparam logic [HOLD_BITS-1:0] HOLD_LIMIT_RESET = 16'd250;
   localparam logic [STEP_BITS-1:0] TICK_STEP_RESET  = 8'd5;

   // Per-button classification
   typedef enum logic [STATE_BITS-1:0] {
      PRESS_RELEASED = 2'd0,
      PRESS_NEW      = 2'd1,
      PRESS_HELD     = 2'd2
   } press_type;

   // Per-lane strobes from the top level
   typedef struct packed {
      logic tick;     // sample tick accepted this cycle
      logic consume;  // read of a new press accepted for this lane
   } lane_ctl_type;

endpackage

>>> src/bphc_lane.sv
// One button lane: saturating hold timer and press state.
// Depends on bphc_pkg.
module bphc_lane #(
   parameter int TIMER_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  bphc_pkg::lane_ctl_type             ctl,
   input  logic                               level,
   input  logic                               prev_level,
   input  logic [bphc_pkg::HOLD_BITS-1:0]     hold_limit,
   input  logic [bphc_pkg::STEP_BITS-1:0]     tick_step,
   output bphc_pkg::press_type                state
);

   localparam int CMP_BITS = (TIMER_BITS > bphc_pkg::HOLD_BITS) ?
                             TIMER_BITS : bphc_pkg::HOLD_BITS;

   logic [TIMER_BITS-1:0]   timer_ff, timer_in;
   bphc_pkg::press_type     state_ff, state_in;
   logic [TIMER_BITS:0]     timer_sum;
   logic [TIMER_BITS-1:0]   timer_sat;
   logic                    over_limit;

   // Advance the timer, saturating at all ones
   assign timer_sum  = {1'b0, timer_ff} + (TIMER_BITS+1)'(tick_step);
   assign timer_sat  = timer_sum[TIMER_BITS] ? '1 : timer_sum[TIMER_BITS-1:0];
   assign over_limit = CMP_BITS'(timer_sat) > CMP_BITS'(hold_limit);

   // Classify on a tick, drop a new press once it has been read
   always_comb begin
      timer_in = timer_ff;
      state_in = state_ff;
      if (ctl.tick) begin
         if (!level) begin
            timer_in = '0;
            state_in = bphc_pkg::PRESS_RELEASED;
         end else if (!prev_level) begin
            timer_in = timer_sat;
            state_in = bphc_pkg::PRESS_NEW;
         end else begin
            timer_in = timer_sat;
            if (over_limit) begin
               state_in = bphc_pkg::PRESS_HELD;
            end
         end
      end else if (ctl.consume) begin
         state_in = bphc_pkg::PRESS_RELEASED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff <= '0;
         state_ff <= bphc_pkg::PRESS_RELEASED;
      end else begin
         timer_ff <= timer_in;
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

>>> src/bphc_merge.sv
// Merge stage: picks the addressed lane's state for a read request and
// holds it in an output register backed by a skid register. Depends on bphc_pkg.
module bphc_merge #(
   parameter int NUM_BUTTONS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                rd_valid,
   input  logic [bphc_pkg::INDEX_BITS-1:0]     rd_index,
   input  bphc_pkg::press_type                 lane_state [NUM_BUTTONS],
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [bphc_pkg::INDEX_BITS-1:0]     rsp_read_index,
   output logic [bphc_pkg::STATE_BITS-1:0]     rsp_press_state,
   output logic                                skid_full
);

   logic                                 out_valid_ff, out_valid_in;
   logic [bphc_pkg::INDEX_BITS-1:0]      out_index_ff, out_index_in;
   logic [bphc_pkg::STATE_BITS-1:0]      out_state_ff, out_state_in;
   logic                                 skid_valid_ff, skid_valid_in;
   logic [bphc_pkg::INDEX_BITS-1:0]      skid_index_ff, skid_index_in;
   logic [bphc_pkg::STATE_BITS-1:0]      skid_state_ff, skid_state_in;
   logic [bphc_pkg::STATE_BITS-1:0]      sel_state;
   logic                                 out_take;

   // Select the addressed lane; an index past the last lane reads released
   always_comb begin
      sel_state = bphc_pkg::PRESS_RELEASED;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         if (32'(rd_index) == i) begin
            sel_state = lane_state[i];
         end
      end
   end

   assign out_take = out_valid_ff && !rsp_stall;

   // Refill the output register from the skid first, else from a new read
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_index_in  = out_index_ff;
      out_state_in  = out_state_ff;
      skid_valid_in = skid_valid_ff;
      skid_index_in = skid_index_ff;
      skid_state_in = skid_state_ff;
      if (!out_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_index_in  = skid_index_ff;
            out_state_in  = skid_state_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = rd_valid;
            out_index_in = rd_index;
            out_state_in = sel_state;
         end
      end else if (rd_valid) begin
         skid_valid_in = 1'b1;
         skid_index_in = rd_index;
         skid_state_in = sel_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_index_ff  <= out_index_in;
      out_state_ff  <= out_state_in;
      skid_index_ff <= skid_index_in;
      skid_state_ff <= skid_state_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_read_index  = out_index_ff;
   assign rsp_press_state = out_state_ff;
   assign skid_full       = skid_valid_ff;

endmodule

>>> src/button_press_hold_classifier.sv
// Top level of the button press/hold classifier: register port, lanes
// and merge stage. Depends on bphc_pkg, bphc_lane and bphc_merge.
//
// Usage:
//  - Request channel (req_valid/req_stall): req_mode 0 is a sample tick that
//    carries all button levels; req_mode 1 reads the state of button
//    req_button_index. A tick gives no response; a read gives exactly one.
//  - Response channel (rsp_valid/rsp_stall): rsp_read_index echoes the index,
//    rsp_press_state is 0 released/consumed, 1 new press, 2 held.
//  - Register port (csr_valid/csr_ready): index 0 hold limit, 1 tick step.
//    csr_ready is always high; write only while the block is idle.
//  - Throughput: one request per cycle while req_stall is low. Every button
//    lane updates in parallel in the cycle of acceptance; a read response is
//    registered in the output register, or in the skid register while that is held.
//  - Reset clears all timers, states, previous levels and the output and skid
//    valid flags, and restores the register defaults (250 and 5).
//  - When the receiver stalls, the response holds and a second read is caught
//    in a skid register; req_stall rises only while that skid register is full.
module button_press_hold_classifier #(
   parameter int NUM_BUTTONS = 12,
   parameter int TIMER_BITS  = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_mode,
   input  logic [bphc_pkg::LEVEL_BITS-1:0]         req_button_levels,
   input  logic [bphc_pkg::INDEX_BITS-1:0]         req_button_index,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [bphc_pkg::INDEX_BITS-1:0]         rsp_read_index,
   output logic [bphc_pkg::STATE_BITS-1:0]         rsp_press_state,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [bphc_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [bphc_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   logic [bphc_pkg::HOLD_BITS-1:0]   hold_limit_ff, hold_limit_in;
   logic [bphc_pkg::STEP_BITS-1:0]   tick_step_ff, tick_step_in;
   logic [bphc_pkg::LEVEL_BITS-1:0]  prev_levels_ff, prev_levels_in;
   logic                             req_accept;
   logic                             tick_accept;
   logic                             read_accept;
   logic                             skid_full;
   bphc_pkg::press_type              lane_state [NUM_BUTTONS];

   assign csr_ready   = 1'b1;
   assign req_stall   = skid_full;
   assign req_accept  = req_valid && !req_stall;
   assign tick_accept = req_accept && (req_mode == bphc_pkg::MODE_TICK);
   assign read_accept = req_accept && (req_mode == bphc_pkg::MODE_READ);

   // Decode register writes
   always_comb begin
      hold_limit_in = hold_limit_ff;
      tick_step_in  = tick_step_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bphc_pkg::CSR_HOLD_LIMIT: hold_limit_in = csr_wdata;
            bphc_pkg::CSR_TICK_STEP:  tick_step_in  = csr_wdata[bphc_pkg::STEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Latch levels on every tick for edge detection
   assign prev_levels_in = tick_accept ? req_button_levels : prev_levels_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_limit_ff  <= bphc_pkg::HOLD_LIMIT_RESET;
         tick_step_ff   <= bphc_pkg::TICK_STEP_RESET;
         prev_levels_ff <= '0;
      end else begin
         hold_limit_ff  <= hold_limit_in;
         tick_step_ff   <= tick_step_in;
         prev_levels_ff <= prev_levels_in;
      end
   end

   // One lane per button; buttons past the level field always read released
   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      bphc_pkg::lane_ctl_type ctl;
      logic                   level;
      logic                   prev_level;

      if (i < bphc_pkg::LEVEL_BITS) begin : g_wired
         assign level      = req_button_levels[i];
         assign prev_level = prev_levels_ff[i];
      end else begin : g_unwired
         assign level      = 1'b0;
         assign prev_level = 1'b0;
      end

      assign ctl.tick    = tick_accept;
      assign ctl.consume = read_accept && (32'(req_button_index) == i) &&
                           (lane_state[i] == bphc_pkg::PRESS_NEW);

      bphc_lane #(
         .TIMER_BITS (TIMER_BITS)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .level      (level),
         .prev_level (prev_level),
         .hold_limit (hold_limit_ff),
         .tick_step  (tick_step_ff),
         .state      (lane_state[i])
      );
   end

   // Pick the addressed lane and hold the response
   bphc_merge #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_merge (
      .clock           (clock),
      .reset           (reset),
      .rd_valid        (read_accept),
      .rd_index        (req_button_index),
      .lane_state      (lane_state),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_read_index  (rsp_read_index),
      .rsp_press_state (rsp_press_state),
      .skid_full       (skid_full)
   );

endmodule
